// ===== hw/rtl/phe_pkg.sv =====
// Package for the Horner polynomial evaluator: constants, register codes, FSM states.
`default_nettype none

package phe_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned NUM_COEF_REGS  = 7;
  localparam int unsigned CNT_W          = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned PROD_W         = 2 * DATA_W;
  localparam int unsigned MAX_COEFFS_DEF = 7;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_NUM_COEFFS = cfg_idx_t'(0);
  localparam cfg_idx_t REG_COEF_BASE  = cfg_idx_t'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/polynomial_horner_eval.sv =====
// Horner polynomial evaluator, signed Q16.16, one shared multiply-add unit.
// Each coefficient takes one multiply step (ST_MUL) and one shift/add/saturate step
//   (ST_ADD), for n = min(num_coeffs, MAX_COEFFS) coefficients.
// A new item is accepted only in ST_IDLE, after the previous result has been taken.
// Reset: asynchronous, active low; clears FSM, num_coeffs and all coefficients to zero.
`default_nettype none

module polynomial_horner_eval #(
  parameter int unsigned MAX_COEFFS = phe_pkg::MAX_COEFFS_DEF,
  parameter int unsigned FRAC_BITS  = phe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [phe_pkg::DATA_W-1:0] arg_x_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [phe_pkg::DATA_W-1:0]  poly_value_o,
  output logic                               overflow_o,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [phe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [phe_pkg::DATA_W-1:0]    cfg_data_i
);

  import phe_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_COEFFS);
  localparam logic signed [PROD_W-1:0] SatMax = PROD_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] SatMin = PROD_W'(-64'sh0000_0000_8000_0000);

  state_e state_q, state_d;

  logic [CNT_W-1:0]               num_coeffs_q;
  logic signed [DATA_W-1:0]       coef_q [NUM_COEF_REGS];
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic signed [DATA_W-1:0]       x_q, x_d;
  logic signed [DATA_W-1:0]       acc_q, acc_d;
  logic                           ovf_q, ovf_d;
  logic signed [PROD_W-1:0]       prod_q, prod_d;

  logic [CNT_W-1:0]               n_eff;
  logic [CNT_W-1:0]               coef_idx;
  logic signed [PROD_W-1:0]       sum;
  logic                           in_acc;
  logic [CFG_IDX_W-1:0]           cfg_coef_idx;

  assign n_eff        = (num_coeffs_q > MaxCnt) ? MaxCnt : num_coeffs_q;
  assign coef_idx     = cnt_q - CNT_W'(1);
  assign sum          = (prod_q >>> FRAC_BITS) + PROD_W'(coef_q[coef_idx]);
  assign in_acc       = in_valid_i && in_ready_o;
  assign cfg_coef_idx = cfg_idx_i - REG_COEF_BASE;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_coeffs_q <= '0;
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NUM_COEFFS) begin
        num_coeffs_q <= cfg_data_i[CNT_W-1:0];
      end else begin
        coef_q[cfg_coef_idx] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    ovf_q  <= ovf_d;
    prod_q <= prod_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    prod_d      = prod_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          x_d   = arg_x_i;
          acc_d = '0;
          ovf_d = 1'b0;
          cnt_d = n_eff;
          state_d = (n_eff == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(acc_q) * PROD_W'(x_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (sum > SatMax) begin
          acc_d = SatMax[DATA_W-1:0];
          ovf_d = 1'b1;
        end else if (sum < SatMin) begin
          acc_d = SatMin[DATA_W-1:0];
          ovf_d = 1'b1;
        end else begin
          acc_d = sum[DATA_W-1:0];
        end
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = (cnt_q == CNT_W'(1)) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign poly_value_o = acc_q;
  assign overflow_o   = ovf_q;

`ifndef ASSERT_OFF
  a_ready_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("step count above coefficient limit");

  a_add_follows_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> state_q == ST_ADD && $stable(cnt_q))
    else $error("multiply not followed by add step");

  a_zero_coeffs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && n_eff == '0 |=> out_valid_o && acc_q == '0 && !ovf_q)
    else $error("empty polynomial did not give zero");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the Horner polynomial evaluator (polynomial_horner_eval).
`timescale 1ns / 100ps

module tb_top;
  import phe_pkg::*;

  localparam int unsigned FRAC        = FRAC_BITS_DEF;
  localparam int unsigned MAX_N       = MAX_COEFFS_DEF;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_N + 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic signed [PROD_W-1:0] SAT_HI = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [PROD_W-1:0] SAT_LO = 64'shffff_ffff_8000_0000;

  typedef logic [NUM_COEF_REGS-1:0][DATA_W-1:0] coef_set_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     ovf;
  } poly_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] arg_x_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] poly_value_o;
  logic                     overflow_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = REG_NUM_COEFFS;
  logic [DATA_W-1:0]        cfg_data_i  = '0;

  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;
  bit          steady_flow  = 1'b0;
  bit          hold_results = 1'b0;

  logic [CNT_W-1:0]         model_count = '0;
  logic signed [DATA_W-1:0] model_coef [NUM_COEF_REGS] = '{default: '0};
  poly_result_t             pending_results [$];

  polynomial_horner_eval u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .arg_x_i     (arg_x_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .poly_value_o(poly_value_o),
    .overflow_o  (overflow_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic poly_result_t horner_eval(input logic signed [DATA_W-1:0] x);
    logic signed [PROD_W-1:0] acc;
    logic signed [PROD_W-1:0] sum;
    poly_result_t res;
    int n;
    int k;
    acc = '0;
    res.ovf = 1'b0;
    n = (model_count > MAX_N) ? MAX_N : model_count;
    for (k = n - 1; k >= 0; k--) begin
      sum = ((acc * x) >>> FRAC) + model_coef[k];
      if (sum > SAT_HI) begin
        sum = SAT_HI;
        res.ovf = 1'b1;
      end else if (sum < SAT_LO) begin
        sum = SAT_LO;
        res.ovf = 1'b1;
      end
      acc = sum;
    end
    res.value = acc[DATA_W-1:0];
    return res;
  endfunction

  // Q16.16 words: full range, small magnitudes, near zero and extremes
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2, 3, 4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      5:       return $urandom_range(0, 32'h1ff_ffff) - 32'h100_0000;
      6:       return $urandom_range(0, 32'h1ff) - 32'h100;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NUM_COEFFS) model_count = data[CNT_W-1:0];
    else model_coef[idx - REG_COEF_BASE] = data;
  endtask

  task automatic load_poly(input int unsigned n, input coef_set_t coefs);
    int unsigned k;
    write_reg(REG_NUM_COEFFS, DATA_W'(n));
    for (k = 0; k < NUM_COEF_REGS; k++) write_reg(cfg_idx_t'(REG_COEF_BASE + k), coefs[k]);
  endtask

  // valid stays up across back-to-back items; lowered only for a gap
  task automatic send_arg(input logic [DATA_W-1:0] x);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    arg_x_i    <= x;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), horner_eval(x));
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_arg(32'h7fff_ffff);
    send_arg(32'h8000_0000);
    send_arg(32'h0000_0000);
    finish_phase();
  endtask

  task automatic test_directed_cases();
    // 1 - 2x + 0.5x^2: exact points, floor of tiny negatives, saturation
    load_poly(3, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_8000, 32'hfffe_0000, 32'h0001_0000});
    send_arg(32'h0000_0000);
    send_arg(32'h0001_0000);
    send_arg(32'hffff_0000);
    send_arg(32'h0000_0001);
    send_arg(32'hffff_ffff);
    send_arg(32'h7fff_ffff);
    send_arg(32'h8000_0000);
    finish_phase();
    // saturation in both directions, later steps continue from the clamp
    load_poly(MAX_N, {NUM_COEF_REGS{32'h7fff_ffff}});
    send_arg(32'h7fff_ffff);
    send_arg(32'h8000_0000);
    send_arg(32'h0000_0000);
    finish_phase();
    load_poly(MAX_N, {NUM_COEF_REGS{32'h8000_0000}});
    send_arg(32'h7fff_ffff);
    send_arg(32'h8000_0000);
    send_arg(32'h0000_0001);
    finish_phase();
    load_poly(1, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1234_5678});
    send_arg(32'hdead_beef);
    send_arg(32'h0000_0000);
    finish_phase();
    // no coefficients in use while registers hold nonzero values
    write_reg(REG_NUM_COEFFS, '0);
    send_arg(32'h0001_0000);
    finish_phase();
  endtask

  task automatic test_random_polys();
    coef_set_t   coefs;
    int unsigned phase;
    int unsigned i;
    int unsigned n;
    for (phase = 0; phase < PHASES; phase++) begin
      for (i = 0; i < NUM_COEF_REGS; i++) coefs[i] = rand_word();
      n = $urandom_range(0, MAX_N);
      case (phase)
        0: n = MAX_N;
        1: begin
          n = MAX_N;
          coefs = {NUM_COEF_REGS{32'h7fff_ffff}};
        end
        2: n = 0;
        3: n = 1;
        default: ;
      endcase
      steady_flow = (phase % 4 == 3);
      load_poly(n, coefs);
      for (i = 0; i < PHASE_ITEMS; i++) send_arg(rand_word());
      finish_phase();
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_output_stall();
    coef_set_t   coefs;
    int unsigned i;
    for (i = 0; i < NUM_COEF_REGS; i++) coefs[i] = rand_word();
    load_poly(MAX_N, coefs);
    steady_flow  = 1'b1;
    hold_results = 1'b1;
    for (i = 0; i < 24; i++) send_arg(rand_word());
    finish_phase();
    steady_flow = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned n;
    forever begin
      if (hold_results) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end
      n = pick_gap();
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    poly_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no item pending", poly_value_o));
      end else begin
        want = pending_results.pop_front();
        if (poly_value_o !== want.value)
          report_mismatch($sformatf("poly_value %h, want %h", poly_value_o, want.value));
        if (overflow_o !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b", overflow_o, want.ovf));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : run_tests
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed_cases();
    test_random_polys();
    test_output_stall();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
